### hw/rtl/wsit_pkg.sv
package wsit_pkg;

  localparam int DAY_COUNT     = 7;
  localparam int HOUR_COUNT    = 24;
  localparam int SLOT_COUNT    = DAY_COUNT * HOUR_COUNT;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);
  localparam int SECS_PER_HOUR = 60 * 60;
  localparam int REM_W         = $clog2(SECS_PER_HOUR);
  localparam int NOW_W         = 32;
  localparam int RUN_W         = 20;
  localparam int TO_W          = 22;
  localparam int HOUR_W        = 5;
  localparam int DAY_W         = 3;
  localparam int SPAN_W        = 5;

  // hour length is 225 << 4; the odd factor goes by a reciprocal multiply
  localparam int HOUR_SHIFT   = 4;
  localparam int RECIP_SHIFT  = 36;
  localparam int RECIP_W      = 29;
  localparam int RECIP_PROD_W = NOW_W - HOUR_SHIFT + RECIP_W;
  localparam int HOUR_Q_W     = 21;
  localparam logic [RECIP_W-1:0] HOUR_RECIP = RECIP_W'(305419897);  // ceil(2^36 / 225)

  localparam logic [HOUR_W-1:0] MAX_HOUR = HOUR_W'(HOUR_COUNT - 1);
  localparam logic [DAY_W-1:0]  MAX_DAY  = DAY_W'(DAY_COUNT - 1);

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [2:0] REG_SAVING_ENABLE    = 3'd0;
  localparam logic [2:0] REG_ACTIVE_TIMEOUT   = 3'd1;
  localparam logic [2:0] REG_WORK_TIMEOUT     = 3'd2;
  localparam logic [2:0] REG_REST_TIMEOUT     = 3'd3;
  localparam logic [2:0] REG_FAILBACK_TIMEOUT = 3'd4;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APREP,
    ST_ADD,
    ST_QSTART,
    ST_QTYPE,
    ST_QBACK,
    ST_QFWD,
    ST_QREM,
    ST_QMUL,
    ST_QFIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  clear;
    logic  wr;
    slot_t waddr;
    logic  rd;
    slot_t raddr;
  } map_req_t;

  function automatic logic [HOUR_W-1:0] clamp_hour(input logic [HOUR_W-1:0] h);
    return (h > MAX_HOUR) ? MAX_HOUR : h;
  endfunction

  function automatic logic [DAY_W-1:0] clamp_day(input logic [DAY_W-1:0] d);
    return (d > MAX_DAY) ? MAX_DAY : d;
  endfunction

  function automatic slot_t slot_of(input logic [DAY_W-1:0] d, input logic [HOUR_W-1:0] h);
    return (slot_t'(d) << 4) + (slot_t'(d) << 3) + slot_t'(h);
  endfunction

  function automatic slot_t slot_inc(input slot_t s);
    return (s == slot_t'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic slot_t slot_dec(input slot_t s);
    return (s == '0) ? slot_t'(SLOT_COUNT - 1) : s - 1'b1;
  endfunction

endpackage

### hw/rtl/wsit_ram.sv
module wsit_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 168
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/wsit_map.sv
module wsit_map (
  input  logic               clk,
  input  logic               rst,
  input  wsit_pkg::map_req_t req,
  output logic               rd_bit
);
  import wsit_pkg::*;

  logic [SLOT_COUNT-1:0] valid;
  logic                  valid_rd;
  logic                  ram_rd;

  // entries never written since the last clear read as rest
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      valid_rd <= valid[req.raddr];
    end
  end

  wsit_ram #(
    .WIDTH(1),
    .DEPTH(SLOT_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr),
    .waddr(req.waddr),
    .wdata(1'b1),
    .re   (req.rd),
    .raddr(req.raddr),
    .rdata(ram_rd)
  );

  assign rd_bit = valid_rd & ram_rd;

endmodule

### hw/rtl/wsit_hrem.sv
module wsit_hrem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wsit_pkg::NOW_W-1:0]   value,
  output logic                         done,
  output logic [wsit_pkg::REM_W-1:0]   rem
);
  import wsit_pkg::*;

  logic [NOW_W-1:0]        val_q;
  logic [RECIP_PROD_W-1:0] prod;
  logic [HOUR_Q_W-1:0]     quot;
  logic                    busy;

  // whole hours by reciprocal multiply, remainder registered in the cycle after
  assign quot = prod[RECIP_SHIFT +: HOUR_Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_q <= value;
      prod  <= RECIP_PROD_W'(value[NOW_W-1:HOUR_SHIFT]) * RECIP_PROD_W'(HOUR_RECIP);
    end
    if (busy) begin
      rem <= REM_W'(val_q - NOW_W'(quot) * NOW_W'(SECS_PER_HOUR));
    end
  end

  assign done = !busy;

endmodule

### hw/rtl/weekly_schedule_idle_timeout_core.sv
// a query's run walk goes over the single read port of the slot map, one slot a
// cycle back then forward, at most 168 slot reads and two read bubbles; the hour
// remainder runs alongside; a finished beat waits in ST_DONE while the output register
// holds an unaccepted result; throughput: one beat at a time, the next beat is taken once the
// result sits in the output register; rst (synchronous) returns the config registers to
// defaults and marks all slots rest at once
module weekly_schedule_idle_timeout_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // day, span_begin_hour, span_end_hour, clock_hour,
                                 // now_seconds, user_action
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // is_work, range_begin, begin_open, range_end, end_open,
                                 // idle_interval
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wsit_pkg::*;

  logic            saving_enable;
  logic [TO_W-1:0] active_timeout;
  logic [TO_W-1:0] work_timeout;
  logic [TO_W-1:0] rest_timeout;
  logic [TO_W-1:0] failback_timeout;
  logic            cfg_we;

  state_t state;
  state_t state_next;

  logic              accept;
  logic [1:0]        kind_q;
  logic [DAY_W-1:0]  day_q;
  logic [HOUR_W-1:0] sb_q;
  logic [HOUR_W-1:0] se_q;
  logic [HOUR_W-1:0] hour_q;
  logic [NOW_W-1:0]  now_q;
  logic              act_q;

  map_req_t          map_req;
  logic              map_bit;
  logic              match;
  slot_t             pos_q;
  slot_t             ptr;
  slot_t             cnt;
  slot_t             back;
  logic [SPAN_W-1:0] nleft;
  logic              type_bit;
  logic              whole;
  logic              rd_live;

  logic             rem_start;
  logic             rem_done;
  logic [REM_W-1:0] rem;

  logic [NOW_W-1:0] trimmed;
  logic [RUN_W-1:0] db;
  logic [RUN_W-1:0] de;
  logic [NOW_W-1:0] rb;
  logic [NOW_W-1:0] re;
  logic [NOW_W:0]   end_sum;

  logic             res_load;
  logic             is_query;
  logic [TO_W-1:0]  passive;
  logic [TO_W-1:0]  idle;
  logic             o_is_work;
  logic [NOW_W-1:0] o_rb;
  logic             o_bo;
  logic [NOW_W-1:0] o_re;
  logic             o_eo;
  logic [TO_W-1:0]  o_idle;

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      saving_enable    <= 1'b1;
      active_timeout   <= TO_W'(600);
      work_timeout     <= TO_W'(21600);
      rest_timeout     <= TO_W'(600);
      failback_timeout <= TO_W'(259200);
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_SAVING_ENABLE:    saving_enable    <= pwdata[0];
        REG_ACTIVE_TIMEOUT:   active_timeout   <= pwdata[TO_W-1:0];
        REG_WORK_TIMEOUT:     work_timeout     <= pwdata[TO_W-1:0];
        REG_REST_TIMEOUT:     rest_timeout     <= pwdata[TO_W-1:0];
        REG_FAILBACK_TIMEOUT: failback_timeout <= pwdata[TO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SAVING_ENABLE:    prdata = {31'd0, saving_enable};
      REG_ACTIVE_TIMEOUT:   prdata = 32'(active_timeout);
      REG_WORK_TIMEOUT:     prdata = 32'(work_timeout);
      REG_REST_TIMEOUT:     prdata = 32'(rest_timeout);
      REG_FAILBACK_TIMEOUT: prdata = 32'(failback_timeout);
      default:              prdata = '0;
    endcase
  end

  // sequencer
  assign accept = s_tvalid & s_tready;
  assign match  = (map_bit == type_bit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            KIND_ADD:   state_next = ST_APREP;
            KIND_QUERY: state_next = ST_QSTART;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_APREP:  state_next = (sb_q == se_q) ? ST_DONE : ST_ADD;
      ST_ADD:    if (nleft == SPAN_W'(1)) state_next = ST_DONE;
      ST_QSTART: state_next = ST_QTYPE;
      ST_QTYPE:  state_next = ST_QBACK;
      ST_QBACK: begin
        if (rd_live && !match) begin
          state_next = ST_QFWD;
        end else if (rd_live && cnt == slot_t'(SLOT_COUNT - 2)) begin
          state_next = ST_QREM;
        end
      end
      ST_QFWD: begin
        if (rd_live && (!match || cnt == slot_t'(SLOT_COUNT - 2))) begin
          state_next = ST_QREM;
        end
      end
      ST_QREM:   if (rem_done) state_next = ST_QMUL;
      ST_QMUL:   state_next = ST_QFIN;
      ST_QFIN:   state_next = ST_DONE;
      ST_DONE:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    res_load      = 1'b0;
    rem_start     = 1'b0;
    map_req       = '0;
    map_req.waddr = ptr;
    map_req.raddr = ptr;
    unique case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        map_req.clear = accept && (s_tuser == KIND_CLEAR);
        rem_start     = accept && (s_tuser == KIND_QUERY);
      end
      ST_ADD:  map_req.wr = 1'b1;
      ST_QSTART: begin
        map_req.rd    = 1'b1;
        map_req.raddr = slot_of(day_q, hour_q);
      end
      ST_QBACK, ST_QFWD: map_req.rd = 1'b1;
      ST_DONE: res_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live <= 1'b0;
    end else begin
      unique case (state)
        ST_QBACK: rd_live <= !(rd_live && !match);
        ST_QFWD:  rd_live <= 1'b1;
        default:  rd_live <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= s_tuser;
      day_q  <= clamp_day(s_tdata[2:0]);
      sb_q   <= clamp_hour(s_tdata[7:3]);
      se_q   <= clamp_hour(s_tdata[12:8]);
      hour_q <= clamp_hour(s_tdata[17:13]);
      now_q  <= s_tdata[49:18];
      act_q  <= s_tdata[50];
    end
    unique case (state)
      ST_APREP: begin
        ptr   <= slot_of(day_q, sb_q);
        nleft <= (sb_q < se_q) ? se_q - sb_q : SPAN_W'(HOUR_COUNT) - sb_q + se_q;
      end
      ST_ADD: begin
        ptr   <= slot_inc(ptr);
        nleft <= nleft - 1'b1;
      end
      ST_QSTART: pos_q <= slot_of(day_q, hour_q);
      ST_QTYPE: begin
        type_bit <= map_bit;
        ptr      <= slot_dec(pos_q);
        cnt      <= '0;
        whole    <= 1'b1;
      end
      ST_QBACK: begin
        if (rd_live && !match) begin
          whole <= 1'b0;
          back  <= cnt;
          cnt   <= '0;
          ptr   <= slot_inc(pos_q);
        end else begin
          ptr <= slot_dec(ptr);
          if (rd_live) begin
            cnt  <= cnt + 1'b1;
            back <= cnt + 1'b1;
          end
        end
      end
      ST_QFWD: begin
        ptr <= slot_inc(ptr);
        if (rd_live && match) begin
          cnt <= cnt + 1'b1;
        end
      end
      ST_QMUL: begin
        db      <= RUN_W'(back) * RUN_W'(SECS_PER_HOUR);
        de      <= (RUN_W'(cnt) + 1'b1) * RUN_W'(SECS_PER_HOUR);
        trimmed <= now_q - NOW_W'(rem);
      end
      ST_QFIN: begin
        rb <= (NOW_W'(db) > trimmed) ? '0 : trimmed - NOW_W'(db);
        re <= end_sum[NOW_W] ? '1 : end_sum[NOW_W-1:0];
      end
      default: ;
    endcase
  end

  assign end_sum = {1'b0, trimmed} + (NOW_W + 1)'(de);

  wsit_map u_map (
    .clk   (clk),
    .rst   (rst),
    .req   (map_req),
    .rd_bit(map_bit)
  );

  wsit_hrem u_hrem (
    .clk  (clk),
    .rst  (rst),
    .start(rem_start),
    .value(s_tdata[49:18]),
    .done (rem_done),
    .rem  (rem)
  );

  // timeout selection
  assign is_query = (kind_q == KIND_QUERY);
  assign passive  = type_bit ? work_timeout : rest_timeout;

  always_comb begin
    if (!saving_enable) begin
      idle = act_q ? failback_timeout : rest_timeout;
    end else if (act_q && active_timeout > passive) begin
      idle = active_timeout;
    end else begin
      idle = passive;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      o_is_work <= is_query & type_bit;
      o_bo      <= is_query & whole;
      o_eo      <= is_query & whole;
      o_idle    <= is_query ? idle : '0;
      if (!is_query) begin
        o_rb <= '0;
        o_re <= '0;
      end else if (whole) begin
        o_rb <= '0;
        o_re <= '1;
      end else begin
        o_rb <= rb;
        o_re <= re;
      end
    end
  end

  assign m_tdata = {7'd0, o_idle, o_eo, o_re, o_bo, o_rb, o_is_work};

  a_query_walks: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == KIND_QUERY |=> state == ST_QSTART)
    else $error("query beat did not start the slot walk");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QBACK || state == ST_QFWD) |-> cnt <= slot_t'(SLOT_COUNT - 2))
    else $error("run walk went past the week");

  a_rem_ready: assert property (@(posedge clk) disable iff (rst)
    state == ST_QMUL |-> rem_done)
    else $error("hour remainder used before it finished");

  a_open_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> o_bo == o_eo)
    else $error("open flags disagree on result beat");

endmodule
